// ----- design/slh_pkg.sv -----
// Shared constants, types and tables for the sRGB to CIELAB/LCh converter.
package slh_pkg;

  localparam int OUT_FRAC = 8;
  localparam int WF = 24;
  localparam int LAB_SH = WF - OUT_FRAC;
  localparam int LMAX_RAW = 100 << OUT_FRAC;
  localparam int LMAX = (LMAX_RAW > 32767) ? 32767 : LMAX_RAW;
  localparam int CH_SH = 16 - OUT_FRAC;
  localparam int CH_RND = 1 << (15 - OUT_FRAC);

  localparam int LW = 25;
  localparam int NW = 48;
  localparam int DW = 24;
  localparam int MW = 32;
  localparam int QW = 26;
  localparam int VW = 36;

  localparam logic [63:0] D_X = 64'd9504700;
  localparam logic [63:0] D_Y = 64'd10000000;
  localparam logic [63:0] D_Z = 64'd10888300;
  localparam logic [63:0] D_F = 64'd3132 << 12;
  localparam logic [63:0] M_X = (64'd1 << 55) / D_X;
  localparam logic [63:0] M_Y = (64'd1 << 55) / D_Y;
  localparam logic [63:0] M_Z = (64'd1 << 55) / D_Z;
  localparam logic [63:0] M_F = (64'd1 << 55) / D_F;

  localparam logic [NW-1:0] RND_X = 48'd4752350;
  localparam logic [NW-1:0] RND_Y = 48'd5000000;
  localparam logic [NW-1:0] RND_Z = 48'd5444150;

  localparam logic [NW-1:0] LABF_K = (48'd432 << 24) + 48'd1566;
  localparam logic [39:0] LABF_THR = 40'd216 << 24;

  localparam int CB_BITS = 25;
  localparam int SQ_BITS = 28;
  localparam int CORDIC_N = 16;

  localparam int FRONT_LAT = 6;
  localparam int LABF_LAT = CB_BITS + 1;
  localparam int POLAR_LAT = SQ_BITS + 4;
  localparam int TOP_LAT = FRONT_LAT + LABF_LAT + 1 + POLAR_LAT;

  typedef logic [LW-1:0] lin_t;
  typedef lin_t lin_tab_t [256];
  typedef logic signed [27:0] ang_t;

  localparam ang_t ATAN_TAB [CORDIC_N] = '{
    28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945,
    28'sd234379, 28'sd117304, 28'sd58666, 28'sd29335,
    28'sd14668, 28'sd7334, 28'sd3667, 28'sd1833,
    28'sd917, 28'sd458, 28'sd229, 28'sd115
  };

  function automatic longint unsigned pow_q(longint unsigned r, int n);
    longint unsigned p;
    int k;
    p = r;
    for (k = 1; k < n; k++) begin
      p = (p * r) >> WF;
    end
    return p;
  endfunction

  function automatic longint unsigned root_q(longint unsigned t, int n);
    longint unsigned r;
    longint unsigned c;
    int b;
    r = 0;
    for (b = 24; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (pow_q(c, n) <= t) begin
        r = c;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned lin_calc(int c);
    longint unsigned cu;
    longint unsigned s;
    longint unsigned s2;
    cu = longint'(c);
    if (cu * 100000 <= 1031475) begin
      return (((cu * 1000) << WF) + 1647300) / 3294600;
    end
    s = ((((1000 * cu) + 14025) << WF) + 134512) / 269025;
    s2 = (s * s) >> WF;
    return (s2 * root_q(s2, 5)) >> WF;
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    int i;
    for (i = 0; i < 256; i++) begin
      tab[i] = LW'(lin_calc(i));
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

// ----- design/slh_cdiv.sv -----
// Three-stage divider by a constant: reciprocal multiply then remainder correction.
module slh_cdiv import slh_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [MW-1:0] recip,
  output logic [QW-1:0] quo
);

  logic [59:0]   p1_r, p1_nxt;
  logic [NW-1:0] n1_r, n2_r;
  logic [24:0]   q2_r, q2_nxt;
  logic [48:0]   t2_r, t2_nxt;
  logic [48:0]   rem;
  logic [QW-1:0] q3_r, q3_nxt;

  always_comb begin
    p1_nxt = 60'(num[NW-1:20]) * 60'(recip);
    q2_nxt = p1_r[59:35];
    t2_nxt = 49'(q2_nxt) * 49'(den);
    rem = 49'(n2_r) - t2_r;
    if (rem >= (49'(den) << 1)) begin
      q3_nxt = QW'(q2_r) + QW'(2);
    end else if (rem >= 49'(den)) begin
      q3_nxt = QW'(q2_r) + QW'(1);
    end else begin
      q3_nxt = QW'(q2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= p1_nxt;
      n1_r <= num;
      q2_r <= q2_nxt;
      t2_r <= t2_nxt;
      n2_r <= n1_r;
      q3_r <= q3_nxt;
    end
  end

  assign quo = q3_r;

endmodule

// ----- design/slh_front.sv -----
// Gamma table lookup, D65 matrix and white-point division to scaled XYZ.
module slh_front import slh_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  output logic [LW-1:0] xs,
  output logic [LW-1:0] ys,
  output logic [LW-1:0] zs
);

  logic [LW-1:0] lr_r, lg_r, lb_r;
  logic [NW-1:0] p_r [9];
  logic [NW-1:0] p_nxt [9];
  logic [NW-1:0] nx_r, ny_r, nz_r;
  logic [QW-1:0] qx, qy, qz;

  always_comb begin
    p_nxt[0] = 48'd4124564 * 48'(lr_r);
    p_nxt[1] = 48'd3575761 * 48'(lg_r);
    p_nxt[2] = 48'd1804375 * 48'(lb_r);
    p_nxt[3] = 48'd2126729 * 48'(lr_r);
    p_nxt[4] = 48'd7151522 * 48'(lg_r);
    p_nxt[5] = 48'd721750 * 48'(lb_r);
    p_nxt[6] = 48'd193339 * 48'(lr_r);
    p_nxt[7] = 48'd1191920 * 48'(lg_r);
    p_nxt[8] = 48'd9503041 * 48'(lb_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lr_r <= LIN_TAB[red];
      lg_r <= LIN_TAB[green];
      lb_r <= LIN_TAB[blue];
      p_r <= p_nxt;
      nx_r <= p_r[0] + p_r[1] + p_r[2] + RND_X;
      ny_r <= p_r[3] + p_r[4] + p_r[5] + RND_Y;
      nz_r <= p_r[6] + p_r[7] + p_r[8] + RND_Z;
    end
  end

  slh_cdiv u_div_x (.clk(clk), .en(en), .num(nx_r), .den(D_X[DW-1:0]),
                    .recip(M_X[MW-1:0]), .quo(qx));
  slh_cdiv u_div_y (.clk(clk), .en(en), .num(ny_r), .den(D_Y[DW-1:0]),
                    .recip(M_Y[MW-1:0]), .quo(qy));
  slh_cdiv u_div_z (.clk(clk), .en(en), .num(nz_r), .den(D_Z[DW-1:0]),
                    .recip(M_Z[MW-1:0]), .quo(qz));

  assign xs = qx[LW-1:0];
  assign ys = qy[LW-1:0];
  assign zs = qz[LW-1:0];

endmodule

// ----- design/slh_labf.sv -----
// CIELAB companding: pipelined bitwise cube root with a linear segment alongside.
module slh_labf import slh_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [LW-1:0] t,
  output logic [LW-1:0] f
);

  logic [LW-1:0] r_r  [CB_BITS];
  logic [49:0]   sq_r [CB_BITS];
  logic [LW-1:0] t_r  [CB_BITS];
  logic          cb_r [CB_BITS];
  logic [LW-1:0] lin_r [3:CB_BITS-1];
  logic [LW-1:0] f_r;
  logic [NW-1:0] lin_num;
  logic [QW-1:0] lin_q;
  logic          cb_in;

  assign lin_num = (48'(t) * 48'd24389 + LABF_K) << 12;
  assign cb_in = (40'(t) * 40'd24389) > LABF_THR;

  slh_cdiv u_div_f (.clk(clk), .en(en), .num(lin_num), .den(D_F[DW-1:0]),
                    .recip(M_F[MW-1:0]), .quo(lin_q));

  for (genvar k = 0; k < CB_BITS; k++) begin : g_step
    localparam int B = CB_BITS - 1 - k;
    logic [LW-1:0] pr, pt, c, r_nxt;
    logic [49:0]   psq, csq, sq_nxt;
    logic          pcb;
    logic [50:0]   c3;
    if (k == 0) begin : g_first
      assign pr = '0;
      assign psq = '0;
      assign pt = t;
      assign pcb = cb_in;
    end else begin : g_next
      assign pr = r_r[k-1];
      assign psq = sq_r[k-1];
      assign pt = t_r[k-1];
      assign pcb = cb_r[k-1];
    end
    always_comb begin
      c = pr | (LW'(1) << B);
      csq = psq + (50'(pr) << (B + 1)) + (50'(1) << (2 * B));
      c3 = 51'(csq[49:24]) * 51'(c);
      if (c3[50:24] <= 27'(pt)) begin
        r_nxt = c;
        sq_nxt = csq;
      end else begin
        r_nxt = pr;
        sq_nxt = psq;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= r_nxt;
        sq_r[k] <= sq_nxt;
        t_r[k] <= pt;
        cb_r[k] <= pcb;
      end
    end
    if (k == 3) begin : g_lin_in
      always_ff @(posedge clk) begin
        if (en) begin
          lin_r[k] <= lin_q[LW-1:0];
        end
      end
    end else if (k > 3) begin : g_lin_hold
      always_ff @(posedge clk) begin
        if (en) begin
          lin_r[k] <= lin_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= cb_r[CB_BITS-1] ? r_r[CB_BITS-1] : lin_r[CB_BITS-1];
    end
  end

  assign f = f_r;

endmodule

// ----- design/slh_polar.sv -----
// Output rounding of L, a, b; CORDIC hue and pipelined square-root chroma.
module slh_polar import slh_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] l24,
  input  logic signed [VW-1:0] a24,
  input  logic signed [VW-1:0] b24,
  output logic [14:0]          lightness,
  output logic [15:0]          green_red_axis,
  output logic [15:0]          blue_yellow_axis,
  output logic [14:0]          hue_angle,
  output logic [15:0]          chroma
);

  localparam int HUE_DLY = POLAR_LAT - CORDIC_N - 2;
  localparam logic signed [VW:0] LAB_RND = (VW + 1)'(1) << (LAB_SH - 1);

  // rounding of L, a and b
  logic signed [VW:0] lx, ax, bx, lr, ar, br;
  logic [14:0] lo;
  logic [15:0] ao, bo;
  logic [14:0] lo_d_r [POLAR_LAT];
  logic [15:0] ao_d_r [POLAR_LAT];
  logic [15:0] bo_d_r [POLAR_LAT];

  always_comb begin
    lx = (VW + 1)'(l24);
    ax = (VW + 1)'(a24);
    bx = (VW + 1)'(b24);
    lr = (lx + LAB_RND) >>> LAB_SH;
    ar = (ax + LAB_RND) >>> LAB_SH;
    br = (bx + LAB_RND) >>> LAB_SH;
    if (lr < 0) begin
      lo = '0;
    end else if (lr > LMAX) begin
      lo = 15'(LMAX);
    end else begin
      lo = lr[14:0];
    end
    if (ar < -32768) begin
      ao = 16'h8000;
    end else if (ar > 32767) begin
      ao = 16'h7fff;
    end else begin
      ao = ar[15:0];
    end
    if (br < -32768) begin
      bo = 16'h8000;
    end else if (br > 32767) begin
      bo = 16'h7fff;
    end else begin
      bo = br[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_d_r[0] <= lo;
      ao_d_r[0] <= ao;
      bo_d_r[0] <= bo;
      for (int i = 1; i < POLAR_LAT; i++) begin
        lo_d_r[i] <= lo_d_r[i-1];
        ao_d_r[i] <= ao_d_r[i-1];
        bo_d_r[i] <= bo_d_r[i-1];
      end
    end
  end

  // hue
  logic signed [37:0] cx_r [CORDIC_N + 1];
  logic signed [37:0] cy_r [CORDIC_N + 1];
  ang_t               ca_r [CORDIC_N + 1];
  logic               cnz_r [CORDIC_N + 1];
  ang_t               hw;
  logic signed [27:0] hr;
  logic [14:0]        h_nxt;
  logic [14:0]        hue_d_r [HUE_DLY + 1];

  always_ff @(posedge clk) begin
    if (en) begin
      cnz_r[0] <= (a24 != 0) || (b24 != 0);
      if (a24 < 0) begin
        cx_r[0] <= -38'(a24);
        cy_r[0] <= -38'(b24);
        ca_r[0] <= 28'sd180 <<< 16;
      end else begin
        cx_r[0] <= 38'(a24);
        cy_r[0] <= 38'(b24);
        ca_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        cnz_r[i+1] <= cnz_r[i];
        if (cy_r[i] >= 0) begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          ca_r[i+1] <= ca_r[i] + ATAN_TAB[i];
        end else begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          ca_r[i+1] <= ca_r[i] - ATAN_TAB[i];
        end
      end
    end
  end

  always_comb begin
    hw = ca_r[CORDIC_N];
    if (hw < 0) begin
      hw = hw + (28'sd360 <<< 16);
    end
    hr = (hw + 28'sd512) >>> 10;
    if (hr >= 23040) begin
      hr = hr - 28'sd23040;
    end
    h_nxt = cnz_r[CORDIC_N] ? hr[14:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_d_r[0] <= h_nxt;
      for (int i = 1; i <= HUE_DLY; i++) begin
        hue_d_r[i] <= hue_d_r[i-1];
      end
    end
  end

  // chroma
  logic signed [28:0] a16_r, b16_r;
  logic signed [VW:0] a16w, b16w;
  logic signed [57:0] asq, bsq;
  logic [55:0]        asq_r, bsq_r, v_r;
  logic [SQ_BITS-1:0] sr_r  [SQ_BITS];
  logic [55:0]        ssq_r [SQ_BITS];
  logic [55:0]        sv_r  [SQ_BITS];
  logic [SQ_BITS:0]   ch_w;
  logic [15:0]        ch_r;

  always_comb begin
    a16w = (ax + (VW + 1)'(128)) >>> 8;
    b16w = (bx + (VW + 1)'(128)) >>> 8;
    asq = 58'(a16_r) * 58'(a16_r);
    bsq = 58'(b16_r) * 58'(b16_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a16_r <= a16w[28:0];
      b16_r <= b16w[28:0];
      asq_r <= asq[55:0];
      bsq_r <= bsq[55:0];
      v_r <= asq_r + bsq_r;
    end
  end

  for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
    localparam int B = SQ_BITS - 1 - k;
    logic [SQ_BITS-1:0] pr;
    logic [55:0]        psq, pv, csq;
    if (k == 0) begin : g_first
      assign pr = '0;
      assign psq = '0;
      assign pv = v_r;
    end else begin : g_next
      assign pr = sr_r[k-1];
      assign psq = ssq_r[k-1];
      assign pv = sv_r[k-1];
    end
    assign csq = psq + (56'(pr) << (B + 1)) + (56'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        sv_r[k] <= pv;
        if (csq <= pv) begin
          sr_r[k] <= pr | (SQ_BITS'(1) << B);
          ssq_r[k] <= csq;
        end else begin
          sr_r[k] <= pr;
          ssq_r[k] <= psq;
        end
      end
    end
  end

  assign ch_w = ((SQ_BITS + 1)'(sr_r[SQ_BITS-1]) + (SQ_BITS + 1)'(CH_RND)) >> CH_SH;

  always_ff @(posedge clk) begin
    if (en) begin
      ch_r <= (ch_w > (SQ_BITS + 1)'(65535)) ? 16'hffff : ch_w[15:0];
    end
  end

  assign lightness = lo_d_r[POLAR_LAT-1];
  assign green_red_axis = ao_d_r[POLAR_LAT-1];
  assign blue_yellow_axis = bo_d_r[POLAR_LAT-1];
  assign hue_angle = hue_d_r[HUE_DLY];
  assign chroma = ch_r;

endmodule

// ----- design/srgb_to_lab_hcl.sv -----
// Top level: sRGB pixel to CIELAB and hue/chroma converter pipeline.
//
// Input word: in_red, in_green, in_blue, in_alpha (gamma-encoded bytes),
// taken when in_valid and in_ready are both high.
// Result word: L, a, b scaled by 256, hue in 1/64 degree (0..23039),
// chroma scaled by 256 and the alpha byte, offered on out_valid and
// taken when out_ready is high.
// Latency is 65 register stages. The stages are 6 for gamma table,
// matrix and white-point division, 26 for the 25-bit cube root (one bit
// per stage) and the segment select, 1 for L/a/b and 32 for output
// rounding, squaring and the 28-bit square root of chroma (one bit per
// stage) with the 16-step hue CORDIC running alongside. Throughput is
// one word per clock while the output is not stalled; the last stage is
// the output register.
// When out_ready is low with a word waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// Reset clears the valid bits only; the block is ready in the first cycle
// after reset.
module srgb_to_lab_hcl import slh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_lightness,
  output logic [15:0] out_green_red_axis,
  output logic [15:0] out_blue_yellow_axis,
  output logic [14:0] out_hue_angle,
  output logic [15:0] out_chroma,
  output logic [7:0]  out_alpha_out
);

  logic                 en;
  logic [TOP_LAT-1:0]   vld_r, vld_nxt;
  logic [7:0]           al_r [TOP_LAT];
  logic [LW-1:0]        xs, ys, zs, fx, fy, fz;
  logic signed [VW-1:0] fxs, fys, fzs;
  logic signed [VW-1:0] l24_r, a24_r, b24_r;

  assign en = !vld_r[TOP_LAT-1] || out_ready;
  assign in_ready = en;
  assign vld_nxt = {vld_r[TOP_LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      al_r[0] <= in_alpha;
      for (int i = 1; i < TOP_LAT; i++) begin
        al_r[i] <= al_r[i-1];
      end
    end
  end

  slh_front u_front (.clk(clk), .en(en), .red(in_red), .green(in_green),
                     .blue(in_blue), .xs(xs), .ys(ys), .zs(zs));

  slh_labf u_labf_x (.clk(clk), .en(en), .t(xs), .f(fx));
  slh_labf u_labf_y (.clk(clk), .en(en), .t(ys), .f(fy));
  slh_labf u_labf_z (.clk(clk), .en(en), .t(zs), .f(fz));

  assign fxs = signed'(VW'(fx));
  assign fys = signed'(VW'(fy));
  assign fzs = signed'(VW'(fz));

  always_ff @(posedge clk) begin
    if (en) begin
      l24_r <= fys * 36'sd116 - (36'sd16 <<< WF);
      a24_r <= (fxs - fys) * 36'sd500;
      b24_r <= (fys - fzs) * 36'sd200;
    end
  end

  slh_polar u_polar (
    .clk(clk), .en(en), .l24(l24_r), .a24(a24_r), .b24(b24_r),
    .lightness(out_lightness), .green_red_axis(out_green_red_axis),
    .blue_yellow_axis(out_blue_yellow_axis), .hue_angle(out_hue_angle),
    .chroma(out_chroma)
  );

  assign out_valid = vld_r[TOP_LAT-1];
  assign out_alpha_out = al_r[TOP_LAT-1];

  a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lightness <= 15'(LMAX))
    else $error("lightness above range");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_angle < 15'd23040)
    else $error("hue not wrapped");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held while output empty");

endmodule

// ----- tb/tb_srgb_to_lab_hcl.sv -----
// Testbench for srgb_to_lab_hcl: directed table and random pixels checked against a predictor.
`timescale 1ns / 100ps

module tb_srgb_to_lab_hcl import slh_pkg::*; ();

  localparam int N_RANDOM = 1430;
  localparam int PIPE_LAT = 65;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [14:0] lightness;
    logic [15:0] gr_axis;
    logic [15:0] by_axis;
    logic [14:0] hue;
    logic [15:0] chroma;
    logic [7:0]  alpha;
  } lab_word_t;

  typedef struct {
    pixel_t    px;
    logic      typed;
    lab_word_t want;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic [7:0]  in_alpha = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] out_lightness;
  logic [15:0] out_green_red_axis;
  logic [15:0] out_blue_yellow_axis;
  logic [14:0] out_hue_angle;
  logic [15:0] out_chroma;
  logic [7:0]  out_alpha_out;

  lab_word_t lab_pending[$];
  int        n_bad = 0;
  bit        feed_done = 1'b0;
  bit        hold_off = 1'b0;

  always #5 clk = ~clk;

  srgb_to_lab_hcl dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_lightness(out_lightness), .out_green_red_axis(out_green_red_axis),
    .out_blue_yellow_axis(out_blue_yellow_axis), .out_hue_angle(out_hue_angle),
    .out_chroma(out_chroma), .out_alpha_out(out_alpha_out)
  );

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned trunc_pow(longint unsigned r, int n);
    longint unsigned p;
    p = r;
    for (int k = 1; k < n; k++) p = (p * r) >> 24;
    return p;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned t, int n);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int bi = 24; bi >= 0; bi--) begin
      c = r | (64'd1 << bi);
      if (trunc_pow(c, n) <= t) r = c;
    end
    return r;
  endfunction

  function automatic longint unsigned to_linear(logic [7:0] ch);
    longint unsigned c;
    longint unsigned s;
    longint unsigned s2;
    c = ch;
    if (c * 100000 <= 1031475) return (((c * 1000) << 24) + 1647300) / 3294600;
    s = ((((1000 * c) + 14025) << 24) + 134512) / 269025;
    s2 = (s * s) >> 24;
    return (s2 * floor_root(s2, 5)) >> 24;
  endfunction

  function automatic longint lab_curve(longint unsigned t);
    if (t * 24389 > (64'd216 << 24)) return longint'(floor_root(t, 3));
    return longint'((t * 24389 + (64'd432 << 24) + 1566) / 3132);
  endfunction

  function automatic longint unsigned chroma_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int bi = 27; bi >= 0; bi--) begin
      c = r | (64'd1 << bi);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_word_t convert_pixel(pixel_t px);
    lab_word_t w;
    longint unsigned lr, lg, lb, xs, ys, zs, c16, chr;
    longint fx, fy, fz, l24, a24, b24, a16, b16, x, y, dx, dy, ang, hue, lmax;
    lr = to_linear(px.red);
    lg = to_linear(px.green);
    lb = to_linear(px.blue);
    xs = (4124564 * lr + 3575761 * lg + 1804375 * lb + 4752350) / 9504700;
    ys = (2126729 * lr + 7151522 * lg + 721750 * lb + 5000000) / 10000000;
    zs = (193339 * lr + 1191920 * lg + 9503041 * lb + 5444150) / 10888300;
    fx = lab_curve(xs);
    fy = lab_curve(ys);
    fz = lab_curve(zs);
    l24 = 116 * fy - (longint'(16) << 24);
    a24 = 500 * (fx - fy);
    b24 = 200 * (fy - fz);
    lmax = longint'(100) << OUT_FRAC;
    if (lmax > 32767) lmax = 32767;
    w.lightness = 15'(sat(rnd_shift(l24, 24 - OUT_FRAC), 0, lmax));
    w.gr_axis = 16'(sat(rnd_shift(a24, 24 - OUT_FRAC), -32768, 32767));
    w.by_axis = 16'(sat(rnd_shift(b24, 24 - OUT_FRAC), -32768, 32767));
    a16 = rnd_shift(a24, 8);
    b16 = rnd_shift(b24, 8);
    c16 = chroma_sqrt(longint'(a16 * a16) + longint'(b16 * b16));
    chr = (c16 + (64'd1 << (15 - OUT_FRAC))) >> (16 - OUT_FRAC);
    if (chr > 65535) chr = 65535;
    w.chroma = 16'(chr);
    hue = 0;
    if (a24 != 0 || b24 != 0) begin
      x = a24;
      y = b24;
      ang = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        ang = longint'(180) << 16;
      end
      for (int i = 0; i < 16; i++) begin
        dx = fl_shift(y, i);
        dy = fl_shift(x, i);
        if (y >= 0) begin
          x += dx;
          y -= dy;
          ang += longint'(ATAN_TAB[i]);
        end else begin
          x -= dx;
          y += dy;
          ang -= longint'(ATAN_TAB[i]);
        end
      end
      if (ang < 0) ang += longint'(360) << 16;
      hue = rnd_shift(ang, 10);
      if (hue >= 23040) hue -= 23040;
    end
    w.hue = 15'(hue);
    w.alpha = px.alpha;
    return w;
  endfunction

  function automatic pixel_row_t row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a);
    pixel_row_t t;
    t.px = '{r, g, b, a};
    t.typed = 1'b0;
    t.want = '0;
    return t;
  endfunction

  function automatic pixel_row_t row_typed(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] a, lab_word_t w);
    pixel_row_t t;
    t = row(r, g, b, a);
    t.typed = 1'b1;
    t.want = w;
    return t;
  endfunction

  task automatic send_pixel(pixel_row_t t);
    in_valid <= 1'b1;
    {in_red, in_green, in_blue, in_alpha} <= t.px;
    lab_pending.push_back(t.typed ? t.want : convert_pixel(t.px));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  pixel_row_t directed[$];

  initial begin
    int burst;
    int sent;
    // black: all zero, hue zero by the zero vector rule
    directed.push_back(row_typed(8'd0, 8'd0, 8'd0, 8'd0, '0));
    directed.push_back(row(8'd255, 8'd255, 8'd255, 8'd255));
    directed.push_back(row(8'd255, 8'd0, 8'd0, 8'd128));
    directed.push_back(row(8'd0, 8'd255, 8'd0, 8'd1));
    directed.push_back(row(8'd0, 8'd0, 8'd255, 8'd254));
    directed.push_back(row(8'd255, 8'd255, 8'd0, 8'd85));
    directed.push_back(row(8'd0, 8'd255, 8'd255, 8'd170));
    directed.push_back(row(8'd255, 8'd0, 8'd255, 8'd15));
    directed.push_back(row(8'd10, 8'd10, 8'd10, 8'd240));
    directed.push_back(row(8'd11, 8'd11, 8'd11, 8'd7));
    directed.push_back(row(8'd128, 8'd128, 8'd128, 8'd64));
    directed.push_back(row(8'd1, 8'd0, 8'd0, 8'd2));
    directed.push_back(row(8'd0, 8'd0, 8'd1, 8'd4));
    directed.push_back(row(8'd0, 8'd1, 8'd0, 8'd8));
    directed.push_back(row(8'd200, 8'd100, 8'd100, 8'd16));
    directed.push_back(row(8'd254, 8'd255, 8'd255, 8'd32));
    directed.push_back(row(8'd255, 8'd254, 8'd255, 8'd127));
    directed.push_back(row(8'd170, 8'd85, 8'd170, 8'd191));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_pixel(directed[i]);
    idle_gap(3);
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        pixel_row_t t;
        if ($urandom_range(0, 4) == 0) begin
          logic [7:0] grey;
          grey = 8'($urandom);
          t = row(grey, grey, grey, 8'($urandom));
        end else begin
          t = row(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        send_pixel(t);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    feed_done = 1'b1;
  end

  initial begin
    int phase;
    phase = 0;
    @(posedge rst_n);
    repeat (300) @(posedge clk);
    // long hold-off so the pipeline fills and backs up the input
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else if (($urandom_range(0, 63) & 8'h30) == 0) begin
      out_ready <= ($urandom_range(0, 1) == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lab_word_t got;
    lab_word_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_lightness, out_green_red_axis, out_blue_yellow_axis,
              out_hue_angle, out_chroma, out_alpha_out};
      if (lab_pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        n_bad++;
      end else begin
        want = lab_pending.pop_front();
        if (got.lightness !== want.lightness) begin
          $display("%0t: lightness exp %0d got %0d", $time, want.lightness, got.lightness);
          n_bad++;
        end
        if (got.gr_axis !== want.gr_axis) begin
          $display("%0t: a exp %0d got %0d", $time, $signed(want.gr_axis),
                   $signed(got.gr_axis));
          n_bad++;
        end
        if (got.by_axis !== want.by_axis) begin
          $display("%0t: b exp %0d got %0d", $time, $signed(want.by_axis),
                   $signed(got.by_axis));
          n_bad++;
        end
        if (got.hue !== want.hue) begin
          $display("%0t: hue exp %0d got %0d", $time, want.hue, got.hue);
          n_bad++;
        end
        if (got.chroma !== want.chroma) begin
          $display("%0t: chroma exp %0d got %0d", $time, want.chroma, got.chroma);
          n_bad++;
        end
        if (got.alpha !== want.alpha) begin
          $display("%0t: alpha exp %0d got %0d", $time, want.alpha, got.alpha);
          n_bad++;
        end
      end
    end
  end

  initial begin
    wait (feed_done);
    while (lab_pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (n_bad == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
